/* sv/smo_pll_pkg.sv */
// shared types and constants for the sliding mode observer with pll
package smo_pll_pkg;

  typedef struct packed {
    logic signed [15:0] volt_alpha;
    logic signed [15:0] volt_beta;
    logic signed [15:0] amp_alpha;
    logic signed [15:0] amp_beta;
  } smo_in_t;

  typedef struct packed {
    logic [15:0]        rotor_angle;
    logic [30:0]        rotor_speed;
    logic signed [15:0] est_amp_alpha;
    logic signed [15:0] est_amp_beta;
  } smo_out_t;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_KP   = 3'd1;
  localparam logic [2:0] REG_KI   = 3'd2;
  localparam logic [2:0] REG_RES  = 3'd3;
  localparam logic [2:0] REG_KL   = 3'd4;
  localparam logic [2:0] REG_AMP  = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MAX_STEPS  = 24;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RA, ST_UA, ST_RB, ST_UB, ST_PRE, ST_CORDIC,
    ST_ERR, ST_KI, ST_KP, ST_PHASE, ST_OUT
  } smo_state_e;

  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* sv/smo_pll_mul.sv */
// shared signed multiplier with registered product
module smo_pll_mul (
  input  logic               clk_i,
  input  logic signed [39:0] a_i,
  input  logic        [15:0] b_i,
  output logic signed [56:0] p_o
);
  logic signed [56:0] p_q;
  logic signed [56:0] p_d;

  assign p_d = 57'(a_i) * $signed({41'd0, b_i});

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;
endmodule

/* sv/smo_pll_cordic.sv */
// iterative vectoring cordic giving the angle of (x, y) in 32-bit turns
module smo_pll_cordic #(
  parameter int STEPS = 16,
  parameter int XW    = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  output logic                 done_o,
  output logic [31:0]          ang_o
);
  import smo_pll_pkg::*;

  localparam int NS = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;

  logic signed [XW-1:0] x_q, x_d, y_q, y_d;
  logic [31:0]          ang_q, ang_d;
  logic [4:0]           i_q, i_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic signed [XW-1:0] dx, dy;

  assign dx = y_q >>> i_q;
  assign dy = x_q >>> i_q;

  always_comb begin
    x_d = x_q; y_d = y_q; ang_d = ang_q; i_d = i_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      i_d = '0;
      if (x_i == '0 && y_i == '0) begin
        ang_d = '0; done_d = 1'b1; busy_d = 1'b0;
      end else begin
        busy_d = 1'b1;
        if (x_i < 0) begin
          x_d = -x_i; y_d = -y_i; ang_d = 32'h80000000;
        end else begin
          x_d = x_i; y_d = y_i; ang_d = '0;
        end
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + dx; y_d = y_q - dy; ang_d = ang_q + atan_turns(i_q);
      end else begin
        x_d = x_q - dx; y_d = y_q + dy; ang_d = ang_q - atan_turns(i_q);
      end
      i_d = i_q + 5'd1;
      if (i_q == 5'(NS - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; i_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; i_q <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; ang_q <= ang_d;
  end

  assign done_o = done_q;
  assign ang_o  = ang_q;
endmodule

/* sv/sliding_mode_observer_pll_core.sv */
// top level: sliding mode current observer feeding a cordic based pll
// Usage: one sample item (alpha/beta voltage and current) enters on in_valid_i /
// in_ready_o; one result item (angle, speed, current estimates) leaves on
// out_valid_o / out_ready_i. Registers are written through cfg_we_i, cfg_idx_i
// and cfg_data_i; the user must write them only while the block is idle,
// as the block itself does not enforce it. The time from acceptance to a
// valid result is set by the cordic iterations and by the one shared
// multiplier that serves the resistive drop, the current step, and both pll
// gains in turn; direct mode skips the observer steps. One item is in work
// at a time; in_ready_o is low from acceptance until the result is taken, so
// a new item is accepted only once the previous result has been taken.
// If the receiver stalls, the result holds on the output register and no new
// item is accepted. Reset clears the angle, speed and current estimates,
// sets observer mode and a switching amplitude of 4915, and zeroes the gains.
module sliding_mode_observer_pll_core #(
  parameter int SAMPLE_BITS  = 16,
  parameter int PHASE_BITS   = 32,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  smo_pll_pkg::smo_in_t                in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output smo_pll_pkg::smo_out_t               out_data_o,
  input  logic                                cfg_we_i,
  input  logic [smo_pll_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [smo_pll_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import smo_pll_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int XW = 36;
  localparam int PMAX = 32;

  smo_state_e st_q, st_d;

  logic        mode_q;
  logic [15:0] kp_q, ki_q, res_q, kl_q;
  logic [14:0] amp_q;

  logic [PMAX-1:0]    phase_q, phase_d;
  logic [30:0]        speed_q, speed_d;
  logic signed [23:0] ea_q, ea_d, eb_q, eb_d;
  logic signed [SB-1:0] va_q, vb_q;
  logic signed [16:0] za_q, zb_q;
  logic signed [39:0] err_q, err_d;
  logic signed [39:0] mul_a;
  logic        [15:0] mul_b;
  logic signed [56:0] prod;
  logic               cor_start, cor_done;
  logic signed [XW-1:0] cx, cy;
  logic [31:0]        cor_ang;
  smo_out_t           out_q, out_d;
  logic               ov_q, ov_d;

  smo_pll_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .p_o(prod));

  smo_pll_cordic #(.STEPS(CORDIC_STEPS), .XW(XW)) u_cordic (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(cor_start), .x_i(cx), .y_i(cy),
    .done_o(cor_done), .ang_o(cor_ang)
  );

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1; kp_q <= '0; ki_q <= '0; res_q <= '0; kl_q <= '0;
      amp_q <= 15'd4915;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE: mode_q <= cfg_data_i[0];
        REG_KP:   kp_q   <= cfg_data_i;
        REG_KI:   ki_q   <= cfg_data_i;
        REG_RES:  res_q  <= cfg_data_i;
        REG_KL:   kl_q   <= cfg_data_i;
        REG_AMP:  amp_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:   if (in_valid_i && !ov_q) st_d = mode_q ? ST_RA : ST_PRE;
      ST_RA:     st_d = ST_UA;
      ST_UA:     st_d = ST_RB;
      ST_RB:     st_d = ST_UB;
      ST_UB:     st_d = ST_PRE;
      ST_PRE:    st_d = ST_CORDIC;
      ST_CORDIC: if (cor_done) st_d = ST_ERR;
      ST_ERR:    st_d = ST_KI;
      ST_KI:     st_d = ST_KP;
      ST_KP:     st_d = ST_PHASE;
      ST_PHASE:  st_d = ST_OUT;
      ST_OUT:    st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  logic signed [40:0] da, db;
  logic signed [29:0] nest;
  logic signed [33:0] spd;
  logic [PMAX-1:0]    tgt, dif;
  logic signed [41:0] adv;

  // datapath and outputs
  always_comb begin
    phase_d = phase_q; speed_d = speed_q; ea_d = ea_q; eb_d = eb_q; err_d = err_q;
    out_d = out_q; ov_d = ov_q;
    mul_a = '0; mul_b = '0; cor_start = 1'b0;
    cx = mode_q ? XW'(za_q) : XW'(va_q);
    cy = mode_q ? XW'(zb_q) : XW'(vb_q);
    da = '0; db = '0; nest = '0; spd = '0; tgt = '0; dif = '0; adv = '0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      ST_RA: begin mul_a = 40'(ea_q); mul_b = res_q; end
      ST_UA: begin
        da = 41'(va_q) - 41'(prod >>> 12) - 41'(za_q);
        mul_a = 40'(da); mul_b = kl_q;
      end
      ST_RB: begin
        nest = 30'(ea_q) + 30'(prod >>> 16);
        ea_d = (nest > 30'sd8388607) ? 24'sh7FFFFF :
               (nest < -30'sd8388608) ? 24'sh800000 : nest[23:0];
        mul_a = 40'(eb_q); mul_b = res_q;
      end
      ST_UB: begin
        db = 41'(vb_q) - 41'(prod >>> 12) - 41'(zb_q);
        mul_a = 40'(db); mul_b = kl_q;
      end
      ST_PRE: begin
        if (mode_q) begin
          nest = 30'(eb_q) + 30'(prod >>> 16);
          eb_d = (nest > 30'sd8388607) ? 24'sh7FFFFF :
                 (nest < -30'sd8388608) ? 24'sh800000 : nest[23:0];
        end
        cor_start = 1'b1;
      end
      ST_ERR: begin
        tgt = PMAX'(cor_ang >> (32 - PHASE_BITS));
        dif = tgt - phase_q;
        err_d = 40'($signed(dif[PHASE_BITS-1:0]));
      end
      ST_KI: begin mul_a = err_q; mul_b = ki_q; end
      ST_KP: begin
        spd = 34'(speed_q) + 34'(prod >>> 16);
        speed_d = (spd < 0) ? 31'd0 : (spd > 34'sh7FFFFFFF) ? 31'h7FFFFFFF : spd[30:0];
        mul_a = err_q; mul_b = kp_q;
      end
      ST_PHASE: begin
        adv = 42'(speed_q) + 42'(prod >>> 8);
        phase_d = PMAX'(phase_q + PMAX'(adv));
        if (PHASE_BITS < PMAX) phase_d = phase_d & PMAX'((64'd1 << PHASE_BITS) - 1);
      end
      ST_OUT: begin
        out_d.rotor_angle = 16'(phase_q >> (PHASE_BITS - 16));
        out_d.rotor_speed = speed_q;
        out_d.est_amp_alpha = 16'((ea_q > 24'((1 << (SB-1)) - 1)) ? 24'((1 << (SB-1)) - 1) :
                              (ea_q < -24'(1 << (SB-1))) ? -24'(1 << (SB-1)) : ea_q);
        out_d.est_amp_beta = 16'((eb_q > 24'((1 << (SB-1)) - 1)) ? 24'((1 << (SB-1)) - 1) :
                             (eb_q < -24'(1 << (SB-1))) ? -24'(1 << (SB-1)) : eb_q);
        ov_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; ov_q <= 1'b0; phase_q <= '0; speed_q <= '0;
      ea_q <= '0; eb_q <= '0;
    end else begin
      st_q <= st_d; ov_q <= ov_d; phase_q <= phase_d; speed_q <= speed_d;
      ea_q <= ea_d; eb_q <= eb_d;
    end
  end

  // capture sample and sliding correction sign; register pll error and output
  always_ff @(posedge clk_i) begin
    err_q <= err_d;
    out_q <= out_d;
    if (st_q == ST_IDLE && in_valid_i && !ov_q) begin
      va_q <= in_data_i.volt_alpha[SB-1:0];
      vb_q <= in_data_i.volt_beta[SB-1:0];
      za_q <= (ea_q > 24'($signed(in_data_i.amp_alpha[SB-1:0]))) ?
              17'(amp_q) : -17'(amp_q);
      zb_q <= (eb_q > 24'($signed(in_data_i.amp_beta[SB-1:0]))) ?
              17'(amp_q) : -17'(amp_q);
    end
  end

  assign in_ready_o  = (st_q == ST_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;
endmodule

/* tb/tb_sliding_mode_observer_pll_core.sv */
// self-checking testbench for the sliding mode observer pll core
`timescale 1ns / 100ps

module tb_sliding_mode_observer_pll_core;
  import smo_pll_pkg::*;

  localparam int MAX_CYCLES = 400000;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  smo_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  smo_out_t out_data_o;
  logic     cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sliding_mode_observer_pll_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // predictor copy of configuration and state
  logic        obs_mode;
  logic [15:0] kp, ki, res, kl;
  logic [14:0] sw_amp;
  logic [31:0] phase_q;
  longint      speed_q, est_a_q, est_b_q;

  smo_out_t expected_q[$];
  bit       failed;
  int       cycles;
  bit       stall_long;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("timeout at %0t", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [31:0] vector_angle(longint x, longint y);
    logic [31:0] ang;
    longint dx, dy;
    ang = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 32'h80000000;
    end
    for (int i = 0; i < 16; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (y > 0) begin
        x += dx;
        y -= dy;
        ang += atan_turns(i[4:0]);
      end else begin
        x -= dx;
        y += dy;
        ang -= atan_turns(i[4:0]);
      end
    end
    return ang;
  endfunction

  function automatic void track_angle(longint x, longint y);
    logic [31:0] diff;
    longint err, adv;
    diff = vector_angle(x, y) - phase_q;
    err = longint'(signed'(diff));
    speed_q = clamp(speed_q + floor_sh(err * longint'(ki), 16), 0, 64'd2147483647);
    adv = speed_q + floor_sh(err * longint'(kp), 8);
    phase_q = phase_q + adv[31:0];
  endfunction

  function automatic longint step_current(longint est, longint v, longint z);
    longint d;
    d = v - floor_sh(est * longint'(res), 12) - z;
    return clamp(est + floor_sh(d * longint'(kl), 16), -8388608, 8388607);
  endfunction

  function automatic smo_out_t predict_sample(smo_in_t s);
    smo_out_t r;
    longint za, zb;
    if (obs_mode) begin
      za = (est_a_q > longint'(s.amp_alpha)) ? longint'(sw_amp) : -longint'(sw_amp);
      zb = (est_b_q > longint'(s.amp_beta)) ? longint'(sw_amp) : -longint'(sw_amp);
      est_a_q = step_current(est_a_q, s.volt_alpha, za);
      est_b_q = step_current(est_b_q, s.volt_beta, zb);
      track_angle(za, zb);
    end else begin
      track_angle(s.volt_alpha, s.volt_beta);
    end
    r.rotor_angle = phase_q[31:16];
    r.rotor_speed = speed_q[30:0];
    r.est_amp_alpha = 16'(clamp(est_a_q, -32768, 32767));
    r.est_amp_beta = 16'(clamp(est_b_q, -32768, 32767));
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_MODE: obs_mode = val[0];
      REG_KP:   kp = val;
      REG_KI:   ki = val;
      REG_RES:  res = val;
      REG_KL:   kl = val;
      REG_AMP:  sw_amp = val[14:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // send one item, optionally after a random gap, and queue its predicted result
  task automatic send_sample(smo_in_t s, bit gapped);
    smo_out_t e;
    if (gapped) repeat (gap_len()) @(negedge clk_i);
    in_data_i = s;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    e = predict_sample(s);
    expected_q.push_back(e);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // receiver side
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= stall_long ? ($urandom_range(0, 15) == 0)
                                          : ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    smo_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result item %h", $time, out_data_o);
        failed = 1'b1;
      end else begin
        e = expected_q.pop_front();
        if (out_data_o.rotor_angle !== e.rotor_angle) begin
          $display("%0t rotor_angle exp %h got %h", $time, e.rotor_angle,
                   out_data_o.rotor_angle);
          failed = 1'b1;
        end
        if (out_data_o.rotor_speed !== e.rotor_speed) begin
          $display("%0t rotor_speed exp %h got %h", $time, e.rotor_speed,
                   out_data_o.rotor_speed);
          failed = 1'b1;
        end
        if (out_data_o.est_amp_alpha !== e.est_amp_alpha) begin
          $display("%0t est_amp_alpha exp %h got %h", $time, e.est_amp_alpha,
                   out_data_o.est_amp_alpha);
          failed = 1'b1;
        end
        if (out_data_o.est_amp_beta !== e.est_amp_beta) begin
          $display("%0t est_amp_beta exp %h got %h", $time, e.est_amp_beta,
                   out_data_o.est_amp_beta);
          failed = 1'b1;
        end
      end
    end
  end

  // directed rows: volt_alpha, volt_beta, amp_alpha, amp_beta
  typedef struct {
    smo_in_t  smp;
    bit       has_exp;
    smo_out_t exp_out;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic smo_in_t mk(int va, int vb, int ia, int ib);
    smo_in_t s;
    s.volt_alpha = 16'(va);
    s.volt_beta = 16'(vb);
    s.amp_alpha = 16'(ia);
    s.amp_beta = 16'(ib);
    return s;
  endfunction

  function automatic smo_in_t rand_sample();
    smo_in_t s;
    s = smo_in_t'({$urandom, $urandom});
    if ($urandom_range(0, 9) == 0) s.amp_alpha = 16'(est_a_q);
    if ($urandom_range(0, 9) == 0) s.volt_alpha = '0;
    if ($urandom_range(0, 9) == 0) s.volt_beta = '0;
    return s;
  endfunction

  task automatic random_phase(int n);
    repeat (n) send_sample(rand_sample(), 1'b1);
    drain();
  endtask

  task automatic rand_config(bit extreme);
    write_reg(REG_MODE, 16'($urandom_range(0, 1)));
    write_reg(REG_KP, extreme ? 16'hFFFF : 16'($urandom_range(0, 65535)));
    write_reg(REG_KI, extreme ? 16'hFFFF : 16'($urandom_range(0, 65535)));
    write_reg(REG_RES, extreme ? 16'hFFFF : 16'($urandom_range(0, 65535)));
    write_reg(REG_KL, extreme ? 16'hFFFF : 16'($urandom_range(0, 65535)));
    write_reg(REG_AMP, extreme ? 16'h7FFF : 16'($urandom_range(0, 32767)));
  endtask

  initial begin
    dir_row_t row;
    smo_out_t zero_out;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    failed = 1'b0;
    cycles = 0;
    stall_long = 1'b0;
    obs_mode = 1'b1;
    kp = '0;
    ki = '0;
    res = '0;
    kl = '0;
    sw_amp = 15'd4915;
    phase_q = '0;
    speed_q = 0;
    est_a_q = 0;
    est_b_q = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // after reset with zero gains everything stays at zero
    zero_out = '0;
    row.has_exp = 1'b1;
    row.exp_out = zero_out;
    row.smp = mk(0, 0, 0, 0);
    dir_rows.push_back(row);
    row.smp = mk(32767, -32768, 32767, -32768);
    dir_rows.push_back(row);
    row.has_exp = 1'b0;
    row.smp = mk(-32768, 32767, -32768, 32767);
    dir_rows.push_back(row);
    foreach (dir_rows[i]) begin
      send_sample(dir_rows[i].smp, 1'b0);
      if (dir_rows[i].has_exp && expected_q[$] !== dir_rows[i].exp_out) begin
        $display("%0t directed row %0d exp %h got prediction %h", $time, i,
                 dir_rows[i].exp_out, expected_q[$]);
        failed = 1'b1;
      end
    end
    drain();

    // observer with live gains, estimate equal to measurement, extremes
    write_reg(REG_KP, 16'h0100);
    write_reg(REG_KI, 16'h0200);
    write_reg(REG_RES, 16'h1000);
    write_reg(REG_KL, 16'h4000);
    dir_rows.delete();
    row.has_exp = 1'b0;
    row.smp = mk(0, 0, 0, 0);
    dir_rows.push_back(row);
    row.smp = mk(32767, 32767, -32768, -32768);
    dir_rows.push_back(row);
    row.smp = mk(-32768, -32768, 32767, 32767);
    dir_rows.push_back(row);
    row.smp = mk(1000, -1000, 0, 0);
    dir_rows.push_back(row);
    foreach (dir_rows[i]) send_sample(dir_rows[i].smp, 1'b0);
    drain();

    // direct mode: zero vector, axes, corners; estimates hold
    write_reg(REG_MODE, 16'd0);
    foreach (dir_rows[i]) send_sample(dir_rows[i].smp, 1'b0);
    send_sample(mk(0, 32767, 0, 0), 1'b0);
    send_sample(mk(-32768, 0, 0, 0), 1'b0);
    send_sample(mk(0, -32768, 0, 0), 1'b0);
    send_sample(mk(-1, -1, 0, 0), 1'b0);
    drain();

    // max gains push speed toward saturation
    rand_config(1'b1);
    write_reg(REG_MODE, 16'd0);
    repeat (12) send_sample(mk(-32768, -1, 0, 0), 1'b0);
    send_sample(mk(32767, 0, 0, 0), 1'b0);
    drain();

    write_reg(REG_AMP, 16'd0);
    write_reg(REG_MODE, 16'hFFFF);
    random_phase(20);

    for (int ph = 0; ph < 6; ph++) begin
      rand_config(ph == 5);
      stall_long = (ph == 2);
      random_phase(60);
    end
    stall_long = 1'b0;
    // small gains keep the loop in its useful range
    write_reg(REG_MODE, 16'd1);
    write_reg(REG_KP, 16'h0080);
    write_reg(REG_KI, 16'h0010);
    write_reg(REG_RES, 16'h0800);
    write_reg(REG_KL, 16'h1000);
    write_reg(REG_AMP, 16'd4915);
    random_phase(40);

    if (!failed) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sliding_mode_observer_pll_core.f */
sv/smo_pll_pkg.sv
sv/smo_pll_mul.sv
sv/smo_pll_cordic.sv
sv/sliding_mode_observer_pll_core.sv
tb/tb_sliding_mode_observer_pll_core.sv
